[src/sppfd_pkg.sv]
package sppfd_pkg;

   localparam int SAMPLE_W    = 24;
   localparam int WORD_W      = 32;
   localparam int GAIN_W      = 16;
   localparam int PAN_W       = 17;
   localparam int TAP_W       = 15;
   localparam int THR_W       = 23;
   localparam int CSR_DATA_W  = 23;
   localparam int CSR_INDEX_W = 3;

   // datapath widths
   localparam int SUM_W     = SAMPLE_W + 1;
   localparam int FB_PROD_W = WORD_W + GAIN_W + 1;
   localparam int IN_PROD_W = SUM_W + PAN_W + 1;
   localparam int IN_SHIFT  = PAN_W - 2;            // weight is 2*pan/65536
   localparam int FB_SH_W   = FB_PROD_W - GAIN_W;
   localparam int IN_SH_W   = IN_PROD_W - IN_SHIFT;
   localparam int TOT_W     = WORD_W + 2;

   localparam int RSP_FIFO_DEPTH = 4;
   localparam int RSP_PTR_W      = 2;
   localparam int RSP_CNT_W      = RSP_PTR_W + 1;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [WORD_W-1:0]   word_type;

   typedef struct packed {
      sample_type in_left;
      sample_type in_right;
      sample_type mix_left;
      sample_type mix_right;
   } req_type;

   typedef struct packed {
      sample_type out_left;
      sample_type out_right;
   } rsp_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TAP_OFFSET      = 3'd0,
      CSR_FEEDBACK_GAIN   = 3'd1,
      CSR_PAN_POSITION    = 3'd2,
      CSR_WET_VOLUME      = 3'd3,
      CSR_PINGPONG_MODE   = 3'd4,
      CSR_NOISE_THRESHOLD = 3'd5
   } csr_index_type;

   localparam logic [PAN_W-1:0]  PAN_FULL   = 17'h1_0000;
   localparam logic [PAN_W-1:0]  PAN_RESET  = 17'h0_8000;
   localparam logic [GAIN_W-1:0] WET_RESET  = 16'hFFFF;
   localparam word_type          WORD_MAX   = 32'sh7FFF_FFFF;
   localparam word_type          WORD_MIN   = 32'sh8000_0000;
   localparam sample_type        SAMPLE_MAX = 24'sh7F_FFFF;
   localparam sample_type        SAMPLE_MIN = 24'sh80_0000;

   function automatic word_type sat_word(input logic signed [TOT_W-1:0] v);
      word_type r;
      if (!v[TOT_W-1] && (v[TOT_W-2:WORD_W-1] != '0)) begin
         r = WORD_MAX;
      end else if (v[TOT_W-1] && (v[TOT_W-2:WORD_W-1] != '1)) begin
         r = WORD_MIN;
      end else begin
         r = v[WORD_W-1:0];
      end
      return r;
   endfunction

   function automatic sample_type sat_sample(input logic signed [TOT_W-1:0] v);
      sample_type r;
      if (!v[TOT_W-1] && (v[TOT_W-2:SAMPLE_W-1] != '0)) begin
         r = SAMPLE_MAX;
      end else if (v[TOT_W-1] && (v[TOT_W-2:SAMPLE_W-1] != '1)) begin
         r = SAMPLE_MIN;
      end else begin
         r = v[SAMPLE_W-1:0];
      end
      return r;
   endfunction

endpackage

[src/stereo_pingpong_feedback_delay.sv]
// channel   direction  handshake              beat
// req       in         req_valid / req_ready  in_left, in_right, mix_left, mix_right
// rsp       out        rsp_valid / rsp_ready  out_left, out_right
// csr       in         csr_write_en           csr_index, csr_wdata (no read-back)
//
// One frame per cycle while req_ready is high; a result goes through read, multiply and sum.
// A frame whose read hits the entry the previous frame writes (delay of one frame) waits
// until that frame has left stage 1, then takes the written word by forwarding.
// After a tap_offset write the read pointer is recomputed; ready stays low until it is done.
// Ring contents are not cleared: entries not yet written since reset read as zero.
// A four-beat result queue absorbs rsp stalls; req_ready drops when it could overfill.
module stereo_pingpong_feedback_delay #(
   parameter int RING_DEPTH = 32768
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  sppfd_pkg::req_type                     req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output sppfd_pkg::rsp_type                     rsp_data,
   input  logic                                   csr_write_en,
   input  logic [sppfd_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [sppfd_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   import sppfd_pkg::*;

   localparam int            AW        = $clog2(RING_DEPTH);
   localparam logic [AW-1:0] POS_LAST  = AW'(RING_DEPTH - 1);
   localparam logic [AW:0]   DEPTH_EXT = (AW + 1)'(RING_DEPTH);
   localparam int            RW        = AW + TAP_W + 1;
   localparam int            STEP_W    = $clog2(TAP_W);
   localparam logic [STEP_W-1:0] STEP_FIRST = STEP_W'(TAP_W - 1);

   // configuration
   logic [GAIN_W-1:0] fg_ff;
   logic [PAN_W-1:0]  pan_ff;
   logic [GAIN_W-1:0] wv_ff;
   logic              pp_ff;
   logic [THR_W-1:0]  thr_ff;

   // tap offset reduction modulo ring depth
   logic              red_busy_ff, red_busy_in;
   logic              red_fix_ff, red_fix_in;
   logic [STEP_W-1:0] red_step_ff, red_step_in;
   logic [TAP_W-1:0]  red_val_ff, red_val_in;
   logic [RW-1:0]     dshift, red_ext, red_sub;
   logic [AW:0]       pos_sum, pos_wrap;
   logic [AW-1:0]     rp_load;
   logic              tap_write;

   // positions
   logic [AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic          wrapped_ff, wrapped_in;
   logic          accept, hazard, credit_ok;
   logic [RSP_CNT_W:0] occupancy;

   // stage 1
   logic          s1_valid_ff;
   req_type       s1_req_ff;
   logic [AW-1:0] s1_wp_ff, s1_rp_ff;
   logic          s1_hit_ff;
   logic [WORD_W-1:0] ram_l_rdata, ram_r_rdata;
   logic          fwd_wr_hit, fwd_lw_hit;
   word_type      dl, dr, fb_src_l, fb_src_r;
   logic [PAN_W-1:0]        pan_c;
   logic signed [GAIN_W:0]  fg_s, wv_s;
   logic signed [PAN_W:0]   pan_l_s, pan_r_s;
   logic signed [SUM_W-1:0] sum;

   // stage 2
   logic                        s2_valid_ff;
   logic [AW-1:0]               s2_wp_ff;
   sample_type                  s2_mix_l_ff, s2_mix_r_ff;
   logic signed [FB_PROD_W-1:0] s2_fb_l_ff, s2_fb_r_ff, s2_wet_l_ff, s2_wet_r_ff;
   logic signed [IN_PROD_W-1:0] s2_in_l_ff, s2_in_r_ff;
   logic signed [FB_SH_W-1:0]   fb_l_sh, fb_r_sh, wet_l_sh, wet_r_sh;
   logic signed [IN_SH_W-1:0]   in_l_sh, in_r_sh;
   word_type                    st_l, st_r, gt_l, gt_r;
   logic [WORD_W-1:0]           mag_l, mag_r;
   rsp_type                     push_data;

   // write-back and forwarding
   logic          wr_valid_ff, lw_valid_ff;
   logic [AW-1:0] wr_addr_ff, lw_addr_ff;
   word_type      wr_l_ff, wr_r_ff, lw_l_ff, lw_r_ff;

   // result queue
   rsp_type              fifo_ff [RSP_FIFO_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] count_ff, count_in;
   logic                 push, pop;

   // ---------------------------------------------------------------- config
   assign tap_write = csr_write_en && (csr_index == CSR_TAP_OFFSET);

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff  <= '0;
         pan_ff <= PAN_RESET;
         wv_ff  <= WET_RESET;
         pp_ff  <= 1'b0;
         thr_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_TAP_OFFSET:      ;  // handled by the reducer
            CSR_FEEDBACK_GAIN:   fg_ff  <= csr_wdata[GAIN_W-1:0];
            CSR_PAN_POSITION:    pan_ff <= csr_wdata[PAN_W-1:0];
            CSR_WET_VOLUME:      wv_ff  <= csr_wdata[GAIN_W-1:0];
            CSR_PINGPONG_MODE:   pp_ff  <= csr_wdata[0];
            CSR_NOISE_THRESHOLD: thr_ff <= csr_wdata[THR_W-1:0];
            default:             ;
         endcase
      end
   end

   // restoring reduction, one shifted copy of the depth per cycle
   assign dshift  = RW'(DEPTH_EXT) << red_step_ff;
   assign red_ext = RW'(red_val_ff);
   assign red_sub = red_ext - dshift;

   assign pos_sum  = {1'b0, wp_ff} + (AW + 1)'(red_val_ff);
   assign pos_wrap = pos_sum - DEPTH_EXT;
   assign rp_load  = (pos_sum >= DEPTH_EXT) ? pos_wrap[AW-1:0] : pos_sum[AW-1:0];

   always_comb begin
      red_busy_in = red_busy_ff;
      red_fix_in  = red_fix_ff;
      red_step_in = red_step_ff;
      red_val_in  = red_val_ff;
      if (tap_write) begin
         red_busy_in = 1'b1;
         red_fix_in  = 1'b0;
         red_step_in = STEP_FIRST;
         red_val_in  = csr_wdata[TAP_W-1:0];
      end else if (red_busy_ff) begin
         if (red_fix_ff) begin
            red_busy_in = 1'b0;
            red_fix_in  = 1'b0;
         end else begin
            if (red_ext >= dshift) begin
               red_val_in = red_sub[TAP_W-1:0];
            end
            if (red_step_ff == '0) begin
               red_fix_in = 1'b1;
            end else begin
               red_step_in = red_step_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         red_busy_ff <= 1'b0;
         red_fix_ff  <= 1'b0;
         red_step_ff <= '0;
      end else begin
         red_busy_ff <= red_busy_in;
         red_fix_ff  <= red_fix_in;
         red_step_ff <= red_step_in;
      end
      red_val_ff <= red_val_in;
   end

   // ------------------------------------------------------------- positions
   assign occupancy = (RSP_CNT_W + 1)'(count_ff) + (RSP_CNT_W + 1)'(s1_valid_ff)
                    + (RSP_CNT_W + 1)'(s2_valid_ff);
   assign credit_ok = occupancy < (RSP_CNT_W + 1)'(RSP_FIFO_DEPTH);
   // the frame ahead still has to compute the word this read wants
   assign hazard    = s1_valid_ff && (s1_wp_ff == rp_ff);
   assign req_ready = !red_busy_ff && !hazard && credit_ok;
   assign accept    = req_valid && req_ready;

   always_comb begin
      wp_in      = wp_ff;
      rp_in      = rp_ff;
      wrapped_in = wrapped_ff;
      if (accept) begin
         wp_in = (wp_ff == POS_LAST) ? '0 : wp_ff + 1'b1;
         rp_in = (rp_ff == POS_LAST) ? '0 : rp_ff + 1'b1;
         if (wp_ff == POS_LAST) begin
            wrapped_in = 1'b1;
         end
      end else if (red_busy_ff && red_fix_ff) begin
         rp_in = rp_load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= '0;
         rp_ff      <= '0;
         wrapped_ff <= 1'b0;
      end else begin
         wp_ff      <= wp_in;
         rp_ff      <= rp_in;
         wrapped_ff <= wrapped_in;
      end
   end

   // ----------------------------------------------------------------- rings
   sppfd_ram #(.WIDTH(WORD_W), .DEPTH(RING_DEPTH)) u_left_ring (
      .clock   (clock),
      .wr_en   (wr_valid_ff),
      .wr_addr (wr_addr_ff),
      .wr_data (wr_l_ff),
      .rd_addr (rp_ff),
      .rd_data (ram_l_rdata)
   );

   sppfd_ram #(.WIDTH(WORD_W), .DEPTH(RING_DEPTH)) u_right_ring (
      .clock   (clock),
      .wr_en   (wr_valid_ff),
      .wr_addr (wr_addr_ff),
      .wr_data (wr_r_ff),
      .rd_addr (rp_ff),
      .rd_data (ram_r_rdata)
   );

   // --------------------------------------------------------------- stage 1
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      s1_req_ff <= req_data;
      s1_wp_ff  <= wp_ff;
      s1_rp_ff  <= rp_ff;
      // entries are filled in order from zero after reset
      s1_hit_ff <= wrapped_ff || (rp_ff < wp_ff);
   end

   assign fwd_wr_hit = wr_valid_ff && (wr_addr_ff == s1_rp_ff);
   assign fwd_lw_hit = lw_valid_ff && (lw_addr_ff == s1_rp_ff);

   always_comb begin
      if (fwd_wr_hit) begin
         dl = wr_l_ff;
         dr = wr_r_ff;
      end else if (fwd_lw_hit) begin
         dl = lw_l_ff;
         dr = lw_r_ff;
      end else if (s1_hit_ff) begin
         dl = ram_l_rdata;
         dr = ram_r_rdata;
      end else begin
         dl = '0;
         dr = '0;
      end
   end

   assign fb_src_l = pp_ff ? dr : dl;
   assign fb_src_r = pp_ff ? dl : dr;
   assign pan_c    = pan_ff[PAN_W-1] ? PAN_FULL : pan_ff;
   assign fg_s     = signed'({1'b0, fg_ff});
   assign wv_s     = signed'({1'b0, wv_ff});
   assign pan_l_s  = signed'({1'b0, PAN_FULL - pan_c});
   assign pan_r_s  = signed'({1'b0, pan_c});
   assign sum      = SUM_W'(s1_req_ff.in_left) + SUM_W'(s1_req_ff.in_right);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_wp_ff    <= s1_wp_ff;
      s2_mix_l_ff <= s1_req_ff.mix_left;
      s2_mix_r_ff <= s1_req_ff.mix_right;
      s2_fb_l_ff  <= fb_src_l * fg_s;
      s2_fb_r_ff  <= fb_src_r * fg_s;
      s2_wet_l_ff <= dl * wv_s;
      s2_wet_r_ff <= dr * wv_s;
      s2_in_l_ff  <= sum * pan_l_s;
      s2_in_r_ff  <= sum * pan_r_s;
   end

   // --------------------------------------------------------------- stage 2
   // arithmetic shifts round toward minus infinity
   assign fb_l_sh  = FB_SH_W'(s2_fb_l_ff >>> GAIN_W);
   assign fb_r_sh  = FB_SH_W'(s2_fb_r_ff >>> GAIN_W);
   assign wet_l_sh = FB_SH_W'(s2_wet_l_ff >>> GAIN_W);
   assign wet_r_sh = FB_SH_W'(s2_wet_r_ff >>> GAIN_W);
   assign in_l_sh  = IN_SH_W'(s2_in_l_ff >>> IN_SHIFT);
   assign in_r_sh  = IN_SH_W'(s2_in_r_ff >>> IN_SHIFT);

   assign st_l = sat_word(TOT_W'(fb_l_sh) + TOT_W'(in_l_sh));
   assign st_r = sat_word(TOT_W'(fb_r_sh) + TOT_W'(in_r_sh));

   // noise gate on the saturated word
   assign mag_l = st_l[WORD_W-1] ? WORD_W'(-st_l) : WORD_W'(st_l);
   assign mag_r = st_r[WORD_W-1] ? WORD_W'(-st_r) : WORD_W'(st_r);
   assign gt_l  = (mag_l < WORD_W'(thr_ff)) ? '0 : st_l;
   assign gt_r  = (mag_r < WORD_W'(thr_ff)) ? '0 : st_r;

   assign push_data.out_left  = sat_sample(TOT_W'(s2_mix_l_ff) + TOT_W'(wet_l_sh));
   assign push_data.out_right = sat_sample(TOT_W'(s2_mix_r_ff) + TOT_W'(wet_r_sh));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_valid_ff <= 1'b0;
         lw_valid_ff <= 1'b0;
      end else begin
         wr_valid_ff <= s2_valid_ff;
         lw_valid_ff <= wr_valid_ff;
      end
      wr_addr_ff <= s2_wp_ff;
      wr_l_ff    <= gt_l;
      wr_r_ff    <= gt_r;
      // last word written, for reads that raced the write
      lw_addr_ff <= wr_addr_ff;
      lw_l_ff    <= wr_l_ff;
      lw_r_ff    <= wr_r_ff;
   end

   // ---------------------------------------------------------- result queue
   assign push      = s2_valid_ff;
   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && rsp_ready;
   assign rsp_data  = fifo_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + RSP_CNT_W'(push) - RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         fifo_ff[wr_ptr_ff] <= push_data;
      end
   end

   // ------------------------------------------------------------ assertions
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |-> (count_ff < RSP_CNT_W'(RSP_FIFO_DEPTH)))
      else $error("result queue overflow");

   a_interlock: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_valid_ff) |-> (s1_rp_ff != s2_wp_ff))
      else $error("read of a word still being computed");

   a_fwd_distinct: assert property (@(posedge clock) disable iff (reset)
      (wr_valid_ff && lw_valid_ff) |-> (wr_addr_ff != lw_addr_ff))
      else $error("consecutive writes to one entry");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      (wp_ff <= POS_LAST) && (rp_ff <= POS_LAST))
      else $error("ring position out of range");

endmodule

[src/sppfd_ram.sv]
module sppfd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32768
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read-first: a read at the address being written returns the old word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
